// File: hdl/rfb_pkg.sv
// Shared types, constants and the CRC-16 helper of the request frame builder.
package rfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] LAST_IDX      = 5'd26;
  localparam logic [4:0] CRC_FIRST_IDX = 5'd10;
  localparam logic [4:0] CRC_LAST_IDX  = 5'd23;
  localparam logic [4:0] CRC_HI_IDX    = 5'd24;
  localparam logic [4:0] CRC_LO_IDX    = 5'd25;

  localparam logic [7:0] FRAME_TYPE    = 8'h15;
  localparam logic [7:0] FRAGMENT_BYTE = 8'h80;
  localparam logic [7:0] CMD_HI        = 8'h0B;
  localparam logic [7:0] CMD_LO        = 8'h00;
  localparam logic [15:0] CRC16_POLY   = 16'hA001;
  localparam logic [15:0] CRC16_RESET  = 16'hFFFF;

  localparam logic REG_SOURCE_ID   = 1'b0;
  localparam logic REG_CRC16_START = 1'b1;

  typedef struct packed {
    logic [31:0] time_seconds;
    logic [31:0] target_id;
  } req_t;

  typedef struct packed {
    logic [31:0] source_id;
    logic [15:0] crc16_start;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC16_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/request_frame_builder_crc_unit.sv
// Top level of the request frame builder with CRC-16 and an XOR checksum byte.
//
//  channel | direction | beat content
//  in_     | slave     | tdata[31:0] target_id, tdata[63:32] time_seconds
//  out_    | master    | tdata[7:0] frame_byte, tdata[12:8] byte_index; tlast is_last
//  cfg_    | APB slave | 0x0 source_id, 0x4 crc16_start
//
// Each request yields 27 output beats, one per cycle while out_tready is high;
// the serializer's byte counter sets this rate, and a request leaves the queue with its last beat.
// A short request queue accepts new requests while a frame is still streaming.
// With a request queued and no stall, a frame starts in the cycle after the last byte.
// Reset is synchronous and active low; the queue and output register come up empty.
// Backpressure on out_tready holds the output register and the byte counter.
module request_frame_builder_crc_unit #(
  parameter int unsigned QUEUE_DEPTH = rfb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] target_id, [63:32] time_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] frame_byte, [12:8] byte_index, [15:13] zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rfb_pkg::*;

  cfg_t       cfg;
  req_t       in_req, head_req;
  logic       q_full, head_valid, pop;
  logic [7:0] frame_byte;
  logic [4:0] byte_index;

  assign in_req.target_id    = in_tdata[31:0];
  assign in_req.time_seconds = in_tdata[63:32];
  assign in_tready           = !q_full;

  rfb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rfb_req_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_data  (in_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_req)
  );

  rfb_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (head_valid),
    .req       (head_req),
    .req_pop   (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (frame_byte),
    .out_index (byte_index),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, byte_index, frame_byte};

endmodule

// File: hdl/rfb_regs.sv
// Configuration registers behind the APB-style port.
module rfb_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output rfb_pkg::cfg_t      cfg
);
  import rfb_pkg::*;

  logic [31:0] source_id_r;
  logic [15:0] crc16_start_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_id_r   <= 32'd0;
      crc16_start_r <= CRC16_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_SOURCE_ID:   source_id_r   <= cfg_pwdata;
        REG_CRC16_START: crc16_start_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SOURCE_ID:   cfg_prdata = source_id_r;
      REG_CRC16_START: cfg_prdata = {16'h0000, crc16_start_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.source_id   = source_id_r;
  assign cfg.crc16_start = crc16_start_r;

endmodule

// File: hdl/rfb_req_fifo.sv
// Request queue between the input side and the frame serializer.
module rfb_req_fifo #(
  parameter int unsigned DEPTH = rfb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfb_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rfb_pkg::req_t head_data
);
  import rfb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  req_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hdl/rfb_serializer.sv
// Frame serializer: emits one frame byte per beat with running CRC-16 and XOR checksum.
module rfb_serializer (
  input  logic          clk,
  input  logic          rst_n,
  input  rfb_pkg::cfg_t cfg,
  input  logic          req_valid,
  input  rfb_pkg::req_t req,
  output logic          req_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [4:0]    out_index,
  output logic          out_last
);
  import rfb_pkg::*;

  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] crc16_r, crc16_in;
  logic [7:0]  crc8_r, crc8_in;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [4:0]  out_index_r;
  logic        out_last_r;
  logic        advance, at_last;
  logic [7:0]  cur_byte;

  assign advance  = req_valid && (!out_valid_r || out_ready);
  assign at_last  = (idx_r == LAST_IDX);
  assign req_pop  = advance && at_last;
  assign idx_nxt  = at_last ? 5'd0 : idx_r + 5'd1;
  assign crc16_in = (idx_r == CRC_FIRST_IDX) ? cfg.crc16_start : crc16_r;
  assign crc8_in  = (idx_r == 5'd0) ? 8'h00 : crc8_r;

  always_comb begin
    unique case (idx_r)
      5'd0:        cur_byte = FRAME_TYPE;
      5'd1:        cur_byte = req.target_id[31:24];
      5'd2:        cur_byte = req.target_id[23:16];
      5'd3:        cur_byte = req.target_id[15:8];
      5'd4:        cur_byte = req.target_id[7:0];
      5'd5:        cur_byte = cfg.source_id[31:24];
      5'd6:        cur_byte = cfg.source_id[23:16];
      5'd7:        cur_byte = cfg.source_id[15:8];
      5'd8:        cur_byte = cfg.source_id[7:0];
      5'd9:        cur_byte = FRAGMENT_BYTE;
      5'd10:       cur_byte = CMD_HI;
      5'd11:       cur_byte = CMD_LO;
      5'd12:       cur_byte = req.time_seconds[31:24];
      5'd13:       cur_byte = req.time_seconds[23:16];
      5'd14:       cur_byte = req.time_seconds[15:8];
      5'd15:       cur_byte = req.time_seconds[7:0];
      CRC_HI_IDX:  cur_byte = crc16_r[15:8];
      CRC_LO_IDX:  cur_byte = crc16_r[7:0];
      LAST_IDX:    cur_byte = crc8_r;
      default:     cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r  <= cur_byte;
      out_index_r <= idx_r;
      out_last_r  <= at_last;
      crc8_r      <= crc8_in ^ cur_byte;
      if (idx_r >= CRC_FIRST_IDX && idx_r <= CRC_LAST_IDX) begin
        crc16_r <= crc16_byte(crc16_in, cur_byte);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

endmodule
